// File: rtl/rdq_pkg.sv
// Shared types, constants and the sort order for the record deque.
package rdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [9:0]  cook;
    logic [15:0] weight;
    logic [1:0]  kind;
    logic [31:0] tag;
  } rec_t;

  typedef struct packed {
    logic shr;  // take left neighbor
    logic shl;  // take right neighbor
    logic wr;   // take write data
  } cell_ctl_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SORT       = 3'd4,
    CMD_LIST       = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_FEW     = 3'd3,
    ST_INVALID = 3'd4
  } status_e;

  localparam logic [1:0] KIND_BAD = 2'd3;

  // True when candidate c must precede current best b.
  function automatic logic goes_before(input rec_t b, input rec_t c);
    goes_before = (b.cook < c.cook) || ((b.cook == c.cook) && (b.weight > c.weight));
  endfunction

endpackage

// File: rtl/record_deque_with_two_key_sort.sv
// Record deque on a chain of cells, front record always in cell 0.
// Push, pop and error results go straight from the transfer into the result register.
// Sort: selection sort, per position one load, a scan over the remaining records and one swap,
//   with every read through the single read port.
// List: one result per stored record, one per cycle while the receiver does not stall.
// Reset (rst_ni low) empties the deque; cell contents are not cleared.
module record_deque_with_two_key_sort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [9:0]  cook_time_i,
  input  logic [15:0] weight_i,
  input  logic [1:0]  grain_kind_i,
  input  logic [31:0] item_tag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  out_cook_time_o,
  output logic [15:0] out_weight_o,
  output logic [1:0]  out_grain_kind_o,
  output logic [31:0] out_tag_o,
  output logic        last_o
);

  localparam int unsigned DEPTH = rdq_pkg::DEPTH;
  localparam int unsigned IDX_W = rdq_pkg::IDX_W;
  localparam int unsigned CNT_W = rdq_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SCAN = 5'b00100,
    S_SWAP = 5'b01000,
    S_LIST = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, best_idx_q, best_idx_d;
  rdq_pkg::rec_t best_q, best_d;

  // Result register
  logic out_valid_q, out_valid_d;
  rdq_pkg::status_e out_status_q, out_status_d;
  rdq_pkg::rec_t out_rec_q, out_rec_d;
  logic out_last_q, out_last_d;

  rdq_pkg::rec_t cells [DEPTH];
  rdq_pkg::cell_ctl_t ctl [DEPTH];
  rdq_pkg::rec_t wr_data [DEPTH];
  rdq_pkg::rec_t in_rec, rd_rec;
  logic [IDX_W-1:0] rd_idx;
  logic out_free, in_xfer, in_bad;

  assign in_rec = '{cook: cook_time_i, weight: weight_i, kind: grain_kind_i, tag: item_tag_i};
  assign in_bad = (cook_time_i == '0) || (weight_i == '0) || (grain_kind_i == rdq_pkg::KIND_BAD);

  // The result register is free when empty or draining this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Single read port into the chain.
  always_comb begin
    unique case (state_q)
      S_SCAN, S_LIST: rd_idx = j_q;
      default:        rd_idx = i_q;
    endcase
  end
  assign rd_rec = cells[rd_idx];

  // Chain of cells: each takes a neighbor on shifts or a write in place.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rdq_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[k]),
      .left_i    ((k == 0) ? in_rec : cells[(k == 0) ? 0 : k - 1]),
      .right_i   ((k == DEPTH - 1) ? cells[k] : cells[(k == DEPTH - 1) ? k : k + 1]),
      .wr_data_i (wr_data[k]),
      .rec_o     (cells[k])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    i_d          = i_q;
    j_d          = j_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_rec_d    = out_rec_q;
    out_last_d   = out_last_q;
    for (int k = 0; k < DEPTH; k++) begin
      ctl[k]     = '0;
      wr_data[k] = in_rec;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          out_rec_d  = '0;
          out_last_d = 1'b1;
          case (command_i)
            rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (in_bad) begin
                out_status_d = rdq_pkg::ST_INVALID;
              end else if (count_q >= CNT_W'(DEPTH)) begin
                out_status_d = rdq_pkg::ST_FULL;
              end else begin
                out_status_d = rdq_pkg::ST_OK;
                count_d      = count_q + 1'b1;
                if (command_i == rdq_pkg::CMD_PUSH_FRONT) begin
                  // Shift every record one cell back, new one enters cell 0.
                  for (int k = 0; k < DEPTH; k++) ctl[k].shr = 1'b1;
                end else begin
                  ctl[count_q[IDX_W-1:0]].wr = 1'b1;
                end
              end
            end
            rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK: begin
              out_valid_d = 1'b1;
              if (count_q == '0) begin
                out_status_d = rdq_pkg::ST_EMPTY;
              end else begin
                out_status_d = rdq_pkg::ST_OK;
                count_d      = count_q - 1'b1;
                if (command_i == rdq_pkg::CMD_POP_FRONT) begin
                  for (int k = 0; k < DEPTH; k++) ctl[k].shl = 1'b1;
                end
              end
            end
            rdq_pkg::CMD_SORT: begin
              if (count_q < CNT_W'(2)) begin
                out_valid_d  = 1'b1;
                out_status_d = rdq_pkg::ST_FEW;
              end else begin
                i_d     = '0;
                state_d = S_LOAD;
              end
            end
            rdq_pkg::CMD_LIST: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = rdq_pkg::ST_EMPTY;
              end else begin
                j_d     = '0;
                state_d = S_LIST;
              end
            end
            default: ;  // unknown command: drop
          endcase
        end
      end
      S_LOAD: begin
        best_d     = rd_rec;
        best_idx_d = i_q;
        j_d        = i_q + 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        // Keep the first best candidate: replace only on strict precedence.
        if (rdq_pkg::goes_before(best_q, rd_rec)) begin
          best_d     = rd_rec;
          best_idx_d = j_q;
        end
        if (CNT_W'(j_q) + CNT_W'(1) == count_q) begin
          state_d = S_SWAP;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_SWAP: begin
        // Old front-of-range record goes to the best slot, best goes forward.
        ctl[best_idx_q].wr  = 1'b1;
        wr_data[best_idx_q] = rd_rec;
        ctl[i_q].wr         = 1'b1;
        wr_data[i_q]        = best_q;
        if (CNT_W'(i_q) + CNT_W'(2) == count_q) begin
          out_valid_d  = 1'b1;
          out_status_d = rdq_pkg::ST_OK;
          out_rec_d    = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = rdq_pkg::ST_OK;
          out_rec_d    = rd_rec;
          out_last_d   = (CNT_W'(j_q) + CNT_W'(1) == count_q);
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and sort working registers: no reset needed.
  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    out_status_q <= out_status_d;
    out_rec_q    <= out_rec_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_cook_time_o  = out_rec_q.cook;
  assign out_weight_o     = out_rec_q.weight;
  assign out_grain_kind_o = out_rec_q.kind;
  assign out_tag_o        = out_rec_q.tag;
  assign last_o           = out_last_q;

endmodule

// File: rtl/rdq_cell.sv
// One storage cell of the record chain.
module rdq_cell (
  input  logic              clk_i,
  input  rdq_pkg::cell_ctl_t ctl_i,
  input  rdq_pkg::rec_t     left_i,
  input  rdq_pkg::rec_t     right_i,
  input  rdq_pkg::rec_t     wr_data_i,
  output rdq_pkg::rec_t     rec_o
);

  rdq_pkg::rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.wr) begin
      rec_d = wr_data_i;
    end else if (ctl_i.shr) begin
      rec_d = left_i;
    end else if (ctl_i.shl) begin
      rec_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// File: test/record_deque_with_two_key_sort_tb.sv
// Testbench for the record deque: scoreboard-checked pushes, pops, sorts and lists.
`timescale 1ns / 1ps

module record_deque_with_two_key_sort_tb;

  localparam int unsigned CAP = rdq_pkg::DEPTH;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One command as it goes into the block.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [9:0]  cook;
    logic [15:0] weight;
    logic [1:0]  kind;
    logic [31:0] tag;
  } order_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  cook;
    logic [15:0] weight;
    logic [1:0]  kind;
    logic [31:0] tag;
    logic        last;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [9:0]  cook_time_i;
  logic [15:0] weight_i;
  logic [1:0]  grain_kind_i;
  logic [31:0] item_tag_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [9:0]  out_cook_time_o;
  logic [15:0] out_weight_o;
  logic [1:0]  out_grain_kind_o;
  logic [31:0] out_tag_o;
  logic        last_o;

  record_deque_with_two_key_sort uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .cook_time_i      (cook_time_i),
    .weight_i         (weight_i),
    .grain_kind_i     (grain_kind_i),
    .item_tag_i       (item_tag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .out_cook_time_o  (out_cook_time_o),
    .out_weight_o     (out_weight_o),
    .out_grain_kind_o (out_grain_kind_o),
    .out_tag_o        (out_tag_o),
    .last_o           (last_o)
  );

  // Shadow copy of the deque: kept as a plain front-to-back list,
  // which is all that the chain of cells in the block has to look like from outside.
  rdq_pkg::rec_t shadow_q[$];
  order_t pending_q[$];
  reply_t expected_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_sender = 1'b0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          stim_done = 1'b0;
  bit          in_took = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Selection sort exactly as the block does it: first best candidate wins,
  // swap it forward even when it is already in place.
  function automatic void sort_shadow();
    int unsigned   best;
    rdq_pkg::rec_t tmp;
    for (int unsigned i = 0; i + 1 < shadow_q.size(); i++) begin
      best = i;
      for (int unsigned j = i + 1; j < shadow_q.size(); j++) begin
        if ((shadow_q[best].cook < shadow_q[j].cook) ||
            ((shadow_q[best].cook == shadow_q[j].cook) &&
             (shadow_q[best].weight > shadow_q[j].weight))) begin
          best = j;
        end
      end
      tmp = shadow_q[i];
      shadow_q[i] = shadow_q[best];
      shadow_q[best] = tmp;
    end
  endfunction

  function automatic void push_status(rdq_pkg::status_e st);
    reply_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  // Work out the replies for one accepted command and update the shadow deque.
  function automatic void predict_replies(order_t o);
    rdq_pkg::rec_t rec;
    reply_t        r;
    rec = '{cook: o.cook, weight: o.weight, kind: o.kind, tag: o.tag};
    case (o.cmd)
      rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK: begin
        // Invalid fields win over a full store.
        if (o.cook == 0 || o.weight == 0 || o.kind == rdq_pkg::KIND_BAD) begin
          push_status(rdq_pkg::ST_INVALID);
        end else if (shadow_q.size() >= CAP) begin
          push_status(rdq_pkg::ST_FULL);
        end else begin
          if (o.cmd == rdq_pkg::CMD_PUSH_FRONT) shadow_q.push_front(rec);
          else shadow_q.push_back(rec);
          push_status(rdq_pkg::ST_OK);
        end
      end
      rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK: begin
        if (shadow_q.size() == 0) begin
          push_status(rdq_pkg::ST_EMPTY);
        end else begin
          if (o.cmd == rdq_pkg::CMD_POP_FRONT) void'(shadow_q.pop_front());
          else void'(shadow_q.pop_back());
          push_status(rdq_pkg::ST_OK);
        end
      end
      rdq_pkg::CMD_SORT: begin
        if (shadow_q.size() < 2) begin
          push_status(rdq_pkg::ST_FEW);
        end else begin
          sort_shadow();
          push_status(rdq_pkg::ST_OK);
        end
      end
      rdq_pkg::CMD_LIST: begin
        if (shadow_q.size() == 0) begin
          push_status(rdq_pkg::ST_EMPTY);
        end else begin
          foreach (shadow_q[k]) begin
            r.status = rdq_pkg::ST_OK;
            r.cook = shadow_q[k].cook;
            r.weight = shadow_q[k].weight;
            r.kind = shadow_q[k].kind;
            r.tag = shadow_q[k].tag;
            r.last = (k == shadow_q.size() - 1);
            expected_q.push_back(r);
          end
        end
      end
      default: ;  // unknown commands give nothing back
    endcase
  endfunction

  // Record the input transfer at the rising edge where it happens.
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_valid_i && !in_stall_o;
  end

  // Driver: present the next pending command at the falling edge; hold it while
  // stalled and advance only after a transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        predict_replies(pending_q.pop_front());
      end
      if (!in_valid_i || in_took) begin
        if (pending_q.size() > 0 && !hold_sender &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          command_i    <= pending_q[0].cmd;
          cook_time_i  <= pending_q[0].cook;
          weight_i     <= pending_q[0].weight;
          grain_kind_i <= pending_q[0].kind;
          item_tag_i   <= pending_q[0].tag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Monitor: check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d tag %h", status_o, out_tag_o);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
          if (out_cook_time_o !== want.cook) begin
            $error("out_cook_time: expected %0d, got %0d", want.cook, out_cook_time_o);
            fail_count++;
          end
          if (out_weight_o !== want.weight) begin
            $error("out_weight: expected %0d, got %0d", want.weight, out_weight_o);
            fail_count++;
          end
          if (out_grain_kind_o !== want.kind) begin
            $error("out_grain_kind: expected %0d, got %0d", want.kind, out_grain_kind_o);
            fail_count++;
          end
          if (out_tag_o !== want.tag) begin
            $error("out_tag: expected %h, got %h", want.tag, out_tag_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("record_deque_with_two_key_sort test failed");
      $finish;
    end
  end

  function automatic order_t make_push(logic [2:0] cmd, logic [9:0] cook,
                                       logic [15:0] weight, logic [1:0] kind,
                                       logic [31:0] tag);
    order_t o;
    o = '{cmd: cmd, cook: cook, weight: weight, kind: kind, tag: tag};
    return o;
  endfunction

  function automatic order_t make_cmd(logic [2:0] cmd);
    return make_push(cmd, 10'($urandom), 16'($urandom), 2'($urandom), $urandom);
  endfunction

  // Random command: valid pushes most often, half of them with small cook times so that ties
  // in the first sort key are common, then pops, lists, sorts, broken pushes and unknown commands.
  function automatic order_t random_order();
    int unsigned pick;
    logic [9:0]  cook;
    logic [15:0] weight;
    pick = $urandom_range(99, 0);
    cook = ($urandom_range(1, 0) != 0) ? 10'($urandom_range(4, 1))
                                       : 10'($urandom_range(1023, 1));
    weight = ($urandom_range(1, 0) != 0) ? 16'($urandom_range(3, 1))
                                         : 16'($urandom_range(65535, 1));
    if (pick < 45) begin
      return make_push(($urandom_range(1, 0) != 0) ? rdq_pkg::CMD_PUSH_FRONT
                                                   : rdq_pkg::CMD_PUSH_BACK,
                       cook, weight, 2'($urandom_range(2, 0)), $urandom);
    end else if (pick < 50) begin
      // broken push: one field out of the legal set
      case ($urandom_range(2, 0))
        0: return make_push(rdq_pkg::CMD_PUSH_BACK, 10'd0, weight, 2'd1, $urandom);
        1: return make_push(rdq_pkg::CMD_PUSH_FRONT, cook, 16'd0, 2'd0, $urandom);
        default: return make_push(rdq_pkg::CMD_PUSH_BACK, cook, weight,
                                  rdq_pkg::KIND_BAD, $urandom);
      endcase
    end else if (pick < 70) begin
      return make_cmd(($urandom_range(1, 0) != 0) ? rdq_pkg::CMD_POP_FRONT
                                                  : rdq_pkg::CMD_POP_BACK);
    end else if (pick < 80) begin
      return make_cmd(rdq_pkg::CMD_SORT);
    end else if (pick < 96) begin
      return make_cmd(rdq_pkg::CMD_LIST);
    end
    return make_cmd(3'($urandom_range(7, 6)));
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned settle;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_stall_i  = 1'b0;
    command_i    = '0;
    cook_time_i  = '0;
    weight_i     = '0;
    grain_kind_i = '0;
    item_tag_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-store cases, invalid pushes, extremes, ties, full store.
    pending_q.push_back(make_cmd(rdq_pkg::CMD_POP_FRONT));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_POP_BACK));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_LIST));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_SORT));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd0, 16'd5, 2'd0, 32'h1));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd5, 16'd0, 2'd0, 32'h2));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_FRONT, 10'd5, 16'd5, rdq_pkg::KIND_BAD,
                                  32'h3));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd1023, 16'hFFFF, 2'd2,
                                  32'hFFFF_FFFF));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_SORT));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_FRONT, 10'd1, 16'd1, 2'd0, 32'h0));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd1023, 16'd1, 2'd1,
                                  32'hA5A5_5A5A));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_SORT));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_LIST));
    pending_q.push_back(make_cmd(3'd6));
    pending_q.push_back(make_cmd(3'd7));
    for (int i = 0; i < 14; i++) begin
      pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_FRONT, 10'(i % 3 + 1), 16'(i % 4 + 1),
                                    2'(i % 3), $urandom));
    end
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd9, 16'd9, 2'd1, 32'h5));
    pending_q.push_back(make_push(rdq_pkg::CMD_PUSH_BACK, 10'd0, 16'd0, rdq_pkg::KIND_BAD,
                                  32'h6));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_SORT));
    pending_q.push_back(make_cmd(rdq_pkg::CMD_LIST));
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 24 : 0;
      recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 24 : 0;
      for (int n = 0; n < 95; n++) pending_q.push_back(random_order());
      if (phase == 1) begin
        // hold the sender until the block has answered everything so far
        while (pending_q.size() > 50) @(posedge clk_i);
        hold_sender = 1'b1;
        wait_drained_partial: while (in_valid_i || expected_q.size() > 0) begin
          @(posedge clk_i);
        end
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    // Let any trailing sort finish before judging.
    settle = 0;
    while (settle < 400) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("record_deque_with_two_key_sort test passed");
    end else begin
      $display("record_deque_with_two_key_sort test failed");
    end
    $finish;
  end

endmodule
